### rtl/core/assert_macros.svh
// Assertion helpers used by the glob matcher tail.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define GWM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("glob matcher assertion failed");
// Next-cycle implication, disabled during reset.
`define GWM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("glob matcher assertion failed");
`else
`define GWM_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define GWM_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

### rtl/core/gwm_pkg.sv
`timescale 1ns / 1ps
package gwm_pkg;

  localparam int PATTERN_MAX_DEF = 64;

  localparam logic [7:0] STAR_CHAR = 8'h2A;
  localparam logic [7:0] ANY_CHAR  = 8'h3F;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_NAME   = 2'd2;
  localparam logic [1:0] MODE_END    = 2'd3;

  typedef enum logic [2:0] {
    TK_NOP    = 3'd0,
    TK_CLEAR  = 3'd1,
    TK_APPEND = 3'd2,
    TK_NAME   = 3'd3,
    TK_END    = 3'd4
  } tok_kind_t;

  // Command that travels down the cell chain, one cell per cycle while the chain is enabled.
  typedef struct packed {
    tok_kind_t   kind;
    logic        pend;   // append byte not yet taken by a cell
    logic [7:0]  data;   // folded byte
  } token_t;

  // Active-bit hand-off to the next cell, aligned with the token.
  typedef struct packed {
    logic pass;   // this position is active and may be skipped (star or empty)
    logic step;   // this position consumed the name byte
  } link_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

### rtl/core/gwm_cell.sv
`timescale 1ns / 1ps
module gwm_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  gwm_pkg::token_t tok_in,
  input  gwm_pkg::link_t  link_in,
  output gwm_pkg::token_t tok_out,
  output gwm_pkg::link_t  link_out
);
  import gwm_pkg::*;

  token_t     tok;
  token_t     tok_next;
  link_t      lnk;
  link_t      lnk_next;
  logic       a;
  logic       a_next;
  logic       valid;
  logic       valid_next;
  logic [7:0] pbyte;
  logic [7:0] pbyte_next;
  logic       star;
  logic       star_next;
  logic       hit;

  assign hit = (pbyte == ANY_CHAR) || (pbyte == tok_in.data);

  always_comb begin
    a_next     = a;
    valid_next = valid;
    pbyte_next = pbyte;
    star_next  = star;
    tok_next   = tok_in;
    lnk_next   = '0;
    unique case (tok_in.kind)
      TK_NAME: begin
        a_next        = (a & valid & star) | link_in.step | link_in.pass;
        lnk_next.step = a & valid & ~star & hit;
        lnk_next.pass = a_next & (~valid | star);
      end
      TK_CLEAR: begin
        valid_next    = 1'b0;
        a_next        = link_in.pass;
        lnk_next.pass = a_next;
      end
      TK_APPEND: begin
        // take the byte if this is the first empty position
        if (tok_in.pend && !valid) begin
          valid_next    = 1'b1;
          pbyte_next    = tok_in.data;
          star_next     = (tok_in.data == STAR_CHAR);
          tok_next.pend = 1'b0;
        end
        a_next        = link_in.pass;
        lnk_next.pass = a_next & (~valid_next | star_next);
      end
      TK_END: begin
        a_next        = link_in.pass;
        lnk_next.pass = a_next & (~valid | star);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok   <= '0;
      lnk   <= '0;
      a     <= 1'b1;
      valid <= 1'b0;
    end else if (en) begin
      tok   <= tok_next;
      lnk   <= lnk_next;
      a     <= a_next;
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pbyte <= pbyte_next;
      star  <= star_next;
    end
  end

  assign tok_out  = tok;
  assign link_out = lnk;

endmodule

### rtl/core/gwm_tail.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gwm_tail (
  input  logic            clk,
  input  logic            rst,
  input  gwm_pkg::token_t tok_in,
  input  gwm_pkg::link_t  link_in,
  input  logic            res_stall,
  output logic            en,
  output logic            res_valid,
  output logic            matched,
  output logic            pattern_overflow
);
  import gwm_pkg::*;

  logic a;
  logic a_next;
  logic ovf;
  logic ovf_next;
  logic emit;

  // hold the whole chain while a result waits
  assign en = ~(res_valid & res_stall);

  always_comb begin
    a_next   = a;
    ovf_next = ovf;
    emit     = 1'b0;
    unique case (tok_in.kind)
      TK_NAME: begin
        a_next = link_in.step | link_in.pass;
      end
      TK_CLEAR: begin
        a_next   = link_in.pass;
        ovf_next = 1'b0;
      end
      TK_APPEND: begin
        a_next = link_in.pass;
        // no cell had room for the byte
        if (tok_in.pend) begin
          ovf_next = 1'b1;
        end
      end
      TK_END: begin
        a_next = link_in.pass;
        emit   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a         <= 1'b1;
      ovf       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (en) begin
        a   <= a_next;
        ovf <= ovf_next;
        if (emit) begin
          res_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && emit) begin
      matched          <= a;
      pattern_overflow <= ovf;
    end
  end

  `GWM_ASSERT_NXT(a_end_gives_result, clk, rst, en && tok_in.kind == TK_END, res_valid)
  `GWM_ASSERT_NXT(a_clear_drops_ovf, clk, rst, en && tok_in.kind == TK_CLEAR, !ovf)
  `GWM_ASSERT_NXT(a_spill_sets_ovf, clk, rst, en && tok_in.kind == TK_APPEND && tok_in.pend, ovf)
  `GWM_ASSERT_NXT(a_hold_state, clk, rst, !en, $stable(a) && $stable(ovf))
  `GWM_ASSERT_NOW(a_stall_freezes, clk, rst, res_valid && res_stall, !en)

endmodule

### rtl/core/glob_wildcard_match.sv
`timescale 1ns / 1ps
// Case-insensitive glob matcher ('*' any run, '?' one byte, A-Z fold to a-z).
// Every item (clear, append pattern byte, name byte, end of name) travels
// down a row of PATTERN_MAX cells, one cell per pattern position and one
// cell per cycle, so one item is taken every cycle while the row is not
// held. An end-of-name item passes through the head register, each cell and
// the tail register, which then shows its match result. While a result waits
// on res_stall the whole row holds and item_stall is high.
module glob_wildcard_match #(
  parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] mode,
  input  logic [7:0] char_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       matched,
  output logic       pattern_overflow
);
  import gwm_pkg::*;

  token_t tok_chain  [PATTERN_MAX+1];
  link_t  link_chain [PATTERN_MAX+1];
  token_t head;
  token_t head_next;
  logic   en;
  logic   accept;

  assign item_stall = ~en;
  assign accept     = item_valid & en;

  always_comb begin
    head_next      = '0;
    head_next.data = fold_case(char_byte);
    if (accept) begin
      unique case (mode)
        MODE_CLEAR:  head_next.kind = TK_CLEAR;
        MODE_APPEND: begin
          head_next.kind = TK_APPEND;
          head_next.pend = 1'b1;
        end
        MODE_NAME:   head_next.kind = TK_NAME;
        MODE_END:    head_next.kind = TK_END;
        default:     head_next.kind = TK_NOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (en) begin
      head <= head_next;
    end
  end

  // position zero is active at the start of every name
  assign tok_chain[0]       = head;
  assign link_chain[0].step = 1'b0;
  assign link_chain[0].pass = (head.kind == TK_CLEAR) || (head.kind == TK_APPEND) ||
                              (head.kind == TK_END);

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    gwm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .tok_in   (tok_chain[k]),
      .link_in  (link_chain[k]),
      .tok_out  (tok_chain[k+1]),
      .link_out (link_chain[k+1])
    );
  end

  gwm_tail u_tail (
    .clk              (clk),
    .rst              (rst),
    .tok_in           (tok_chain[PATTERN_MAX]),
    .link_in          (link_chain[PATTERN_MAX]),
    .res_stall        (res_stall),
    .en               (en),
    .res_valid        (res_valid),
    .matched          (matched),
    .pattern_overflow (pattern_overflow)
  );

endmodule

### tb/tb_glob_wildcard_match.sv
`timescale 1ns / 1ps
module tb_glob_wildcard_match;
  import gwm_pkg::*;

  localparam int PATTERN_MAX = PATTERN_MAX_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = PATTERN_MAX + 40;
  localparam int PHASE_ITEMS = 450;
  localparam logic [PATTERN_MAX:0] REARM_POS = {{PATTERN_MAX{1'b0}}, 1'b1};

  typedef struct packed {
    logic matched;
    logic overflow;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [1:0] mode = MODE_CLEAR;
  logic [7:0] char_byte = 8'h00;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic       matched;
  logic       pattern_overflow;

  glob_wildcard_match #(
    .PATTERN_MAX(PATTERN_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .mode(mode),
    .char_byte(char_byte),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .matched(matched),
    .pattern_overflow(pattern_overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Matcher state as the testbench sees it
  logic [7:0]           glob_bytes [PATTERN_MAX];
  int                   glob_len = 0;
  logic [PATTERN_MAX:0] live_pos = REARM_POS;
  logic                 glob_overflow = 1'b0;
  verdict_t             pending_verdicts [$];

  int send_gap_pct = 0;
  int res_stall_pct = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  logic [7:0] pat_buf [$];
  logic [7:0] name_buf [$];

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    if (b >= "A" && b <= "Z") return b | 8'h20;
    return b;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] b);
    if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) return b ^ 8'h20;
    return b;
  endfunction

  // A live star position also makes the next position live (empty run).
  function automatic logic [PATTERN_MAX:0] close_over_stars(input logic [PATTERN_MAX:0] v);
    for (int i = 0; i < glob_len; i++) begin
      if (v[i] && glob_bytes[i] == STAR_CHAR) v[i+1] = 1'b1;
    end
    return v;
  endfunction

  task automatic predict_item(input logic [1:0] m, input logic [7:0] b);
    logic [PATTERN_MAX:0] cur;
    logic [PATTERN_MAX:0] nxt;
    verdict_t v;
    case (m)
      MODE_CLEAR: begin
        glob_len = 0;
        glob_overflow = 1'b0;
        live_pos = REARM_POS;
      end
      MODE_APPEND: begin
        if (glob_len < PATTERN_MAX) begin
          glob_bytes[glob_len] = b;
          glob_len++;
        end else begin
          glob_overflow = 1'b1;
        end
        live_pos = REARM_POS;
      end
      MODE_NAME: begin
        cur = close_over_stars(live_pos);
        nxt = '0;
        for (int i = 0; i < glob_len; i++) begin
          if (cur[i]) begin
            if (glob_bytes[i] == STAR_CHAR) nxt[i] = 1'b1;
            else if (glob_bytes[i] == ANY_CHAR || to_lower(glob_bytes[i]) == to_lower(b))
              nxt[i+1] = 1'b1;
          end
        end
        live_pos = nxt;
      end
      MODE_END: begin
        cur = close_over_stars(live_pos);
        v.matched = cur[glob_len];
        v.overflow = glob_overflow;
        pending_verdicts.push_back(v);
        live_pos = REARM_POS;
      end
    endcase
  endtask

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] pool [4] = '{"a", "b", "A", "B"};
    return pool[$urandom_range(0, 3)];
  endfunction

  function automatic logic [7:0] pick_pattern_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return STAR_CHAR;
    if (r < 40) return ANY_CHAR;
    if (r < 85) return pick_letter();
    return rand_byte();
  endfunction

  function automatic logic [7:0] pick_name_byte();
    if ($urandom_range(0, 99) < 80) return pick_letter();
    return rand_byte();
  endfunction

  // Expand pat_buf into a name that mostly matches, then spoil some.
  task automatic build_name();
    logic [7:0] c;
    name_buf.delete();
    foreach (pat_buf[i]) begin
      if (pat_buf[i] == STAR_CHAR) begin
        repeat ($urandom_range(0, 3)) name_buf.push_back(pick_name_byte());
      end else if (pat_buf[i] == ANY_CHAR) begin
        name_buf.push_back(pick_name_byte());
      end else begin
        c = pat_buf[i];
        if ($urandom_range(0, 1) == 1) c = flip_case(c);
        name_buf.push_back(c);
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: name_buf.push_back(pick_name_byte());
        1: if (name_buf.size() > 0) name_buf.delete($urandom_range(0, name_buf.size() - 1));
        default: if (name_buf.size() > 0)
          name_buf[$urandom_range(0, name_buf.size() - 1)] = pick_name_byte();
      endcase
    end
  endtask

  // Call at a rising edge; returns at the edge of the transfer with valid still high.
  task automatic send_item(input logic [1:0] m, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    mode <= m;
    char_byte <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predict_item(m, b);
    items_sent++;
  endtask

  task automatic wait_all_verdicts();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    res_stall <= ($urandom_range(0, 99) < res_stall_pct);
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_verdicts.size() == 0) begin
        $error("result transfer with no pending expectation");
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (matched !== want.matched) begin
          $error("matched: expected %0b, got %0b", want.matched, matched);
          mismatch_count++;
        end
        if (pattern_overflow !== want.overflow) begin
          $error("pattern_overflow: expected %0b, got %0b", want.overflow, pattern_overflow);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (res_valid && !res_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic test_empty_and_star_patterns();
    send_item(MODE_END, 8'hFF);
    send_item(MODE_NAME, "x");
    send_item(MODE_END, 8'h00);
    send_item(MODE_CLEAR, 8'hFF);
    send_item(MODE_APPEND, STAR_CHAR);
    send_item(MODE_END, 8'h00);
    // trailing double star against an exhausted name
    send_item(MODE_APPEND, STAR_CHAR);
    send_item(MODE_END, 8'h00);
    send_item(MODE_NAME, 8'h00);
    send_item(MODE_END, 8'h00);
    send_item(MODE_APPEND, ANY_CHAR);
    send_item(MODE_END, 8'h00);
  endtask

  task automatic test_literals_and_case();
    send_item(MODE_CLEAR, 8'h00);
    send_item(MODE_APPEND, "A");
    send_item(MODE_APPEND, ANY_CHAR);
    send_item(MODE_APPEND, 8'h00);
    send_item(MODE_APPEND, 8'hFF);
    send_item(MODE_NAME, "a");
    send_item(MODE_NAME, "Z");
    send_item(MODE_NAME, 8'h00);
    send_item(MODE_NAME, 8'hFF);
    send_item(MODE_END, 8'hFF);
    send_item(MODE_NAME, "A");
    send_item(MODE_NAME, STAR_CHAR);
    send_item(MODE_NAME, 8'h00);
    send_item(MODE_END, 8'h00);
  endtask

  task automatic test_append_mid_name();
    send_item(MODE_CLEAR, 8'h5A);
    send_item(MODE_APPEND, "b");
    send_item(MODE_NAME, "a");
    // the append drops the partial name
    send_item(MODE_APPEND, "c");
    send_item(MODE_NAME, "B");
    send_item(MODE_NAME, "C");
    send_item(MODE_END, 8'h00);
  endtask

  task automatic test_pattern_overflow();
    send_item(MODE_CLEAR, 8'h00);
    for (int i = 0; i < PATTERN_MAX; i++)
      send_item(MODE_APPEND, (i % 2 == 0) ? STAR_CHAR : ANY_CHAR);
    send_item(MODE_APPEND, "z");
    send_item(MODE_APPEND, "z");
    repeat (PATTERN_MAX / 2) send_item(MODE_NAME, rand_byte());
    send_item(MODE_END, 8'h00);
    send_item(MODE_END, 8'h00);
    send_item(MODE_CLEAR, 8'h00);
    send_item(MODE_END, 8'h00);
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int n_items);
    int first;
    int plen;
    logic [1:0] m;
    send_gap_pct = gap_pct;
    res_stall_pct = stall_pct;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 9) != 0) send_item(MODE_CLEAR, rand_byte());
        plen = ($urandom_range(0, 29) == 0) ?
               $urandom_range(PATTERN_MAX - 4, PATTERN_MAX + 4) : $urandom_range(0, 6);
        pat_buf.delete();
        repeat (plen) pat_buf.push_back(pick_pattern_byte());
        foreach (pat_buf[i]) send_item(MODE_APPEND, pat_buf[i]);
        repeat ($urandom_range(1, 4)) begin
          build_name();
          foreach (name_buf[i]) begin
            send_item(MODE_NAME, name_buf[i]);
            if ($urandom_range(0, 49) == 0) send_item(MODE_APPEND, pick_pattern_byte());
          end
          send_item(MODE_END, rand_byte());
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          m = 2'($urandom_range(0, 3));
          send_item(m, rand_byte());
        end
      end
      if ($urandom_range(0, 39) == 0) wait_all_verdicts();
    end
    wait_all_verdicts();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_star_patterns();
    test_literals_and_case();
    test_append_mid_name();
    test_pattern_overflow();
    test_random_traffic(0, 0, PHASE_ITEMS);
    test_random_traffic(65, 0, PHASE_ITEMS);
    test_random_traffic(0, 65, PHASE_ITEMS);
    test_random_traffic(11, 11, PHASE_ITEMS);
    wait_all_verdicts();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/gwm_pkg.sv
rtl/core/gwm_cell.sv
rtl/core/gwm_tail.sv
rtl/core/glob_wildcard_match.sv
tb/tb_glob_wildcard_match.sv
